>>> rtl/position_protection_monitor_assert.svh
// ----------------------------------------------------------------------------
// position protection monitor assertion macros
// shared property forms for the monitor's concurrent checks
// ----------------------------------------------------------------------------
`ifndef POSITION_PROTECTION_MONITOR_ASSERT_SVH
`define POSITION_PROTECTION_MONITOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("position protection monitor check failed");

// next-cycle implication, disabled during reset
`define PPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("position protection monitor check failed");

`endif

>>> rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// field widths, register map and shared types of the position monitor
// ----------------------------------------------------------------------------
package ppm_pkg;

    // field widths
    localparam int POS_W = 24;
    localparam int CUR_W = 20;
    localparam int REC_W = 8;
    localparam int THR_W = 23;

    // register map
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_DISC_POS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISC_CUR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRAKE    = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] DISC_POS_RST = 23'd100;
    localparam logic [CUR_W-1:0] DISC_CUR_RST = 20'd6000;
    localparam logic [THR_W-1:0] BRAKE_RST    = 23'd8388607;

    // sticky protection flags
    typedef struct packed {
        logic disconnect;
        logic backwards;
        logic braking;
    } t_flags;

endpackage

>>> rtl/ppm_cell.sv
// ----------------------------------------------------------------------------
// ppm_cell
// one slot of the position window; passes its sample on at every transfer
// ----------------------------------------------------------------------------
module ppm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [ppm_pkg::POS_W-1:0]  i_sample,
    output logic [ppm_pkg::POS_W-1:0]  o_sample
);

    logic [ppm_pkg::POS_W-1:0] r_sample;

    // empty slots read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

>>> rtl/ppm_avg_div.sv
// ----------------------------------------------------------------------------
// ppm_avg_div
// two-stage divide of the window sum by the window length
// ----------------------------------------------------------------------------
module ppm_avg_div #(
    parameter int WINDOW_LENGTH = 10,
    parameter int SUM_W         = 28
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [SUM_W-1:0]           i_abs,
    input  logic                       i_neg,
    input  ppm_pkg::t_flags            i_flags,
    output logic [ppm_pkg::POS_W-1:0]  o_avg,
    output ppm_pkg::t_flags            o_flags
);

    // reciprocal exact for every magnitude below 2**SUM_W
    localparam int DIV_L       = $clog2(WINDOW_LENGTH);
    localparam int RECIP_SHIFT = SUM_W + DIV_L;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic [PROD_W-1:0]          r_prod;
    logic                       r_neg;
    ppm_pkg::t_flags            r_flags_mul;
    logic [ppm_pkg::POS_W-1:0]  w_quot;
    logic [ppm_pkg::POS_W-1:0]  n_avg;
    logic [ppm_pkg::POS_W-1:0]  r_avg;
    ppm_pkg::t_flags            r_flags_out;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod      <= PROD_W'(i_abs) * PROD_W'(RECIP);
            r_neg       <= i_neg;
            r_flags_mul <= i_flags;
        end
    end

    // shift and restore sign, truncating toward zero
    assign w_quot = r_prod[RECIP_SHIFT +: ppm_pkg::POS_W];
    assign n_avg  = r_neg ? (~w_quot + 1'b1) : w_quot;

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_avg       <= n_avg;
            r_flags_out <= r_flags_mul;
        end
    end

    assign o_avg   = r_avg;
    assign o_flags = r_flags_out;

endmodule

>>> rtl/position_protection_monitor.sv
// ----------------------------------------------------------------------------
// position_protection_monitor
// moving-window position check with sticky disconnect, backwards and
// braking-zone flags
// ----------------------------------------------------------------------------
// Takes one position sample per clock while the output is not stalled and
// returns one result per sample. The window is a row of WINDOW_LENGTH cells
// that shift on every input transfer, with a running sum. Each result moves
// through four register stages: window sum and compares, sticky flags and
// sum magnitude, then the two stages of the reciprocal multiply that forms
// the average. A stall on the output holds the whole pipeline, so input
// ready drops only while a result waits. Flags are sticky and clear only at
// reset. Registers: 0 disconnect position, 1 disconnect current, 2 braking
// distance, at byte addresses 0, 4 and 8.
module position_protection_monitor #(
    parameter int WINDOW_LENGTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ppm_pkg::POS_W-1:0]      i_position_mm,
    input  logic [ppm_pkg::CUR_W-1:0]      i_current_peak_ma,
    input  logic [ppm_pkg::REC_W-1:0]      i_recovery_state,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_disconnect_flag,
    output logic                           o_backwards_flag,
    output logic                           o_braking_zone_flag,
    output logic [ppm_pkg::POS_W-1:0]      o_window_average_mm,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppm_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

`include "position_protection_monitor_assert.svh"

    localparam int SUM_W = ppm_pkg::POS_W + $clog2(WINDOW_LENGTH);

    logic [ppm_pkg::THR_W-1:0]      r_disc_pos;
    logic [ppm_pkg::CUR_W-1:0]      r_disc_cur;
    logic [ppm_pkg::THR_W-1:0]      r_brake;
    logic [ppm_pkg::REG_IDX_W-1:0]  w_reg_idx;

    logic                           w_en;
    logic                           w_accept;
    wire  [ppm_pkg::POS_W-1:0]      w_chain [0:WINDOW_LENGTH];

    logic signed [SUM_W-1:0]        r_sum;
    logic signed [SUM_W-1:0]        n_sum;
    logic [ppm_pkg::POS_W-1:0]      r_prev;
    logic                           r_v1;
    logic                           r_cur_hi;
    logic                           r_back;
    logic                           r_brake_hit;

    logic [SUM_W-1:0]               w_thr_scaled;
    logic                           w_disc_hit;
    logic                           r_v2;
    ppm_pkg::t_flags                r_flags;
    ppm_pkg::t_flags                n_flags;
    logic [SUM_W-1:0]               r_abs;
    logic                           r_neg;

    logic                           r_v3;
    logic                           r_out_valid;
    ppm_pkg::t_flags                w_out_flags;

    // configuration registers
    assign w_reg_idx = paddr[ppm_pkg::ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_pos <= ppm_pkg::DISC_POS_RST;
            r_disc_cur <= ppm_pkg::DISC_CUR_RST;
            r_brake    <= ppm_pkg::BRAKE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                ppm_pkg::REG_DISC_POS: r_disc_pos <= pwdata[ppm_pkg::THR_W-1:0];
                ppm_pkg::REG_DISC_CUR: r_disc_cur <= pwdata[ppm_pkg::CUR_W-1:0];
                ppm_pkg::REG_BRAKE:    r_brake    <= pwdata[ppm_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg_idx)
            ppm_pkg::REG_DISC_POS: prdata = 32'(r_disc_pos);
            ppm_pkg::REG_DISC_CUR: prdata = 32'(r_disc_cur);
            ppm_pkg::REG_BRAKE:    prdata = 32'(r_brake);
            default:               prdata = '0;
        endcase
    end

    // pipeline moves unless a result waits at the output
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_accept   = i_in_valid && w_en;

    // window cells, newest sample at the head
    assign w_chain[0] = i_position_mm;

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
        ppm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_sample (w_chain[g]),
            .o_sample (w_chain[g+1])
        );
    end

    // running sum drops the oldest sample and adds the new one
    assign n_sum = r_sum - SUM_W'($signed(w_chain[WINDOW_LENGTH]))
                         + SUM_W'($signed(i_position_mm));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
            r_v1   <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_accept;
            if (w_accept) begin
                r_sum  <= n_sum;
                r_prev <= i_position_mm;
            end
        end
    end

    // per-sample compares
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_hi    <= i_current_peak_ma > r_disc_cur;
            r_back      <= ($signed(i_position_mm) < $signed(r_prev))
                           && (i_recovery_state == '0);
            r_brake_hit <= !i_position_mm[ppm_pkg::POS_W-1]
                           && (i_position_mm[ppm_pkg::THR_W-1:0] >= r_brake);
        end
    end

    // exact average compare: sum against threshold times window length
    assign w_thr_scaled = SUM_W'(r_disc_pos) * SUM_W'(WINDOW_LENGTH);
    assign w_disc_hit   = r_cur_hi && (r_sum < $signed(w_thr_scaled));

    always_comb begin
        n_flags            = r_flags;
        n_flags.disconnect = r_flags.disconnect || w_disc_hit;
        n_flags.backwards  = r_flags.backwards  || r_back;
        n_flags.braking    = r_flags.braking    || r_brake_hit;
    end

    // sticky flags and sum magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_v2    <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            if (r_v1) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v1) begin
            r_abs <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_neg <= r_sum[SUM_W-1];
        end
    end

    // average divider
    ppm_avg_div #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_abs   (r_abs),
        .i_neg   (r_neg),
        .i_flags (r_flags),
        .o_avg   (o_window_average_mm),
        .o_flags (w_out_flags)
    );

    // valid bits of the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_disconnect_flag   = w_out_flags.disconnect;
    assign o_backwards_flag    = w_out_flags.backwards;
    assign o_braking_zone_flag = w_out_flags.braking;

    // flags never clear once set
    `PPM_ASSERT_NEXT(a_flags_sticky, i_clk, i_rst_n, 1'b1, (r_flags & $past(r_flags)) == $past(r_flags))
    // a result in the multiply stage reaches the output on the next move
    `PPM_ASSERT_NEXT(a_result_advances, i_clk, i_rst_n, w_en && r_v3, r_out_valid)
    // a delivered result never shows a flag the live state lacks
    `PPM_ASSERT_NOW(a_out_flags_subset, i_clk, i_rst_n, r_out_valid, (w_out_flags & ~r_flags) == '0)

endmodule
